// ===== design/bitmap_text_character_renderer_defines.svh =====
// Assertion macros shared by the character renderer.
`ifndef BITMAP_TEXT_CHARACTER_RENDERER_DEFINES_SVH
`define BITMAP_TEXT_CHARACTER_RENDERER_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define BTCR_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The condition holds in the cycle after the trigger.
`define BTCR_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

// The condition holds in the cycle after the trigger, reset included.
`define BTCR_ASSERT_NEXT_ALWAYS(label, clk, trig, cond, msg) \
   label: assert property (@(posedge clk) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== design/btcr_pkg.sv =====
// Types, codes and the font table of the character renderer.
`default_nettype none

package btcr_pkg;

   localparam logic REQ_MOVE = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   localparam logic [7:0] LOWER_FIRST = 8'd97;
   localparam logic [7:0] LOWER_LAST  = 8'd122;
   localparam logic [7:0] UPPER_FIRST = 8'd65;
   localparam logic [7:0] UPPER_LAST  = 8'd90;
   localparam logic [7:0] DIGIT_FIRST = 8'd48;
   localparam logic [7:0] DIGIT_LAST  = 8'd57;
   localparam logic [7:0] DIGIT_BIAS  = 8'd22;
   localparam logic [7:0] CHAR_DOT    = 8'd46;
   localparam logic [7:0] CHAR_COLON  = 8'd58;
   localparam logic [7:0] CHAR_BANG   = 8'd33;
   localparam logic [7:0] CHAR_DASH   = 8'd45;
   localparam logic [7:0] CHAR_UNDER  = 8'd95;

   localparam logic [5:0] GLYPH_DOT   = 6'd36;
   localparam logic [5:0] GLYPH_COLON = 6'd37;
   localparam logic [5:0] GLYPH_BANG  = 6'd38;
   localparam logic [5:0] GLYPH_DASH  = 6'd39;
   localparam logic [5:0] GLYPH_UNDER = 6'd40;
   localparam logic [5:0] GLYPH_BLANK = 6'd41;

   localparam logic [7:0] CELL_STEP = 8'd8;
   localparam logic [5:0] PIXEL_LAST = 6'd63;

   typedef struct packed {
      logic [5:0] glyph;
      logic [7:0] col;
      logic [7:0] row;
   } btcr_job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } btcr_queue_status_type;

   function automatic logic [5:0] btcr_glyph_index(input logic [7:0] code);
      logic [7:0] d;
      case (code) inside
         [LOWER_FIRST:LOWER_LAST]: d = code - LOWER_FIRST;
         [UPPER_FIRST:UPPER_LAST]: d = code - UPPER_FIRST;
         [DIGIT_FIRST:DIGIT_LAST]: d = code - DIGIT_BIAS;
         CHAR_DOT:                 d = {2'b00, GLYPH_DOT};
         CHAR_COLON:               d = {2'b00, GLYPH_COLON};
         CHAR_BANG:                d = {2'b00, GLYPH_BANG};
         CHAR_DASH:                d = {2'b00, GLYPH_DASH};
         CHAR_UNDER:               d = {2'b00, GLYPH_UNDER};
         default:                  d = {2'b00, GLYPH_BLANK};
      endcase
      return d[5:0];
   endfunction

   // Row r of a glyph sits in bits 8r+7 down to 8r, column 0 in the low bit.
   function automatic logic [63:0] btcr_glyph_bits(input logic [5:0] g);
      logic [63:0] b;
      case (g)
         6'd0:        b = 64'h1111_111f_0a0a_0a04;
         6'd1:        b = 64'h0f11_110f_0909_0907;
         6'd2:        b = 64'h0e11_0101_0101_110e;
         6'd3:        b = 64'h0709_1111_1111_0907;
         6'd4:        b = 64'h1f01_010f_0101_011f;
         6'd5:        b = 64'h0101_010f_0101_011f;
         6'd6:        b = 64'h0e11_1119_0101_110e;
         6'd7:        b = 64'h1111_111f_1111_1111;
         6'd8:        b = 64'h1f04_0404_0404_041f;
         6'd9:        b = 64'h0609_0808_0808_081f;
         6'd10:       b = 64'h1111_0907_0305_0911;
         6'd11:       b = 64'h1f01_0101_0101_0101;
         6'd12:       b = 64'h1111_1111_1115_1b11;
         6'd13:       b = 64'h1111_1915_1513_1111;
         6'd14:       b = 64'h0e11_1111_1111_110e;
         6'd15:       b = 64'h0101_010f_1111_110f;
         6'd16:       b = 64'h1609_1111_1111_110e;
         6'd17:       b = 64'h1111_090f_1111_110f;
         6'd18:       b = 64'h0e11_100e_0101_110e;
         6'd19:       b = 64'h0404_0404_0404_041f;
         6'd20:       b = 64'h0e11_1111_1111_1111;
         6'd21:       b = 64'h0404_0a0a_0a11_1111;
         6'd22:       b = 64'h0a15_1515_1111_1111;
         6'd23:       b = 64'h1111_0a04_040a_1111;
         6'd24:       b = 64'h0404_0404_0a11_1111;
         6'd25:       b = 64'h1f01_0204_0810_101f;
         6'd26:       b = 64'h0e11_1515_1515_110e;
         6'd27:       b = 64'h1f04_0404_0404_0406;
         6'd28:       b = 64'h1f01_0204_0810_110e;
         6'd29:       b = 64'h0e11_1008_0408_101f;
         6'd30:       b = 64'h1010_101f_1111_1110;
         6'd31:       b = 64'h0e11_100e_0101_111f;
         6'd32:       b = 64'h0e11_110f_0101_110e;
         6'd33:       b = 64'h0404_0404_0810_111f;
         6'd34:       b = 64'h0e11_1111_0e11_110e;
         6'd35:       b = 64'h1010_1010_1e11_110e;
         GLYPH_DOT:   b = 64'h0400_0000_0000_0000;
         GLYPH_COLON: b = 64'h0000_0400_0004_0000;
         GLYPH_BANG:  b = 64'h0400_0404_0404_0404;
         GLYPH_DASH:  b = 64'h0000_000e_0000_0000;
         GLYPH_UNDER: b = 64'h1f00_0000_0000_0000;
         default:     b = 64'h0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== design/btcr_front.sv =====
// Request front end: cursor tracking and glyph lookup for draw jobs.
`default_nettype none

module btcr_front #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [23:0]                   req_tdata,
   input  wire logic                          req_tuser,
   input  wire btcr_pkg::btcr_queue_status_type q_status,
   output logic                               q_push,
   output btcr_pkg::btcr_job_type             q_job
);
   import btcr_pkg::*;

   localparam logic [8:0] COL_LIMIT = 9'(SCREEN_WIDTH - 8);
   localparam logic [8:0] ROW_LIMIT = 9'(SCREEN_HEIGHT - 8);

   logic [7:0] cursor_col_ff, cursor_col_in;
   logic [7:0] cursor_row_ff, cursor_row_in;
   logic       accept;
   logic [7:0] col_step;
   logic [7:0] row_step;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && (req_tuser == REQ_DRAW);

   assign q_job.glyph = btcr_glyph_index(req_tdata[7:0]);
   assign q_job.col   = cursor_col_ff;
   assign q_job.row   = cursor_row_ff;

   assign col_step = cursor_col_ff + CELL_STEP;
   assign row_step = cursor_row_ff + CELL_STEP;

   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (accept && (req_tuser == REQ_MOVE)) begin
         cursor_col_in = req_tdata[15:8];
         cursor_row_in = req_tdata[23:16];
      end else if (q_push) begin
         cursor_col_in = col_step;
         if ({1'b0, col_step} > COL_LIMIT) begin
            cursor_col_in = 8'd0;
            cursor_row_in = ({1'b0, row_step} > ROW_LIMIT) ? 8'd0 : row_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 8'd0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/btcr_queue.sv =====
// Two-entry job queue between the front end and the pixel engine.
`default_nettype none

module btcr_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire btcr_pkg::btcr_job_type          push_job,
   input  wire logic                            pop,
   output btcr_pkg::btcr_job_type               pop_job,
   output btcr_pkg::btcr_queue_status_type      status
);
   import btcr_pkg::*;

   btcr_job_type entries_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push;
   logic         do_pop;

   assign status.full      = (count_ff == 2'd2);
   assign status.not_empty = (count_ff != 2'd0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign pop_job          = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== design/btcr_back.sv =====
// Pixel engine: walks the 64 pixels of each queued glyph into the output register.
`default_nettype none

module btcr_back #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire btcr_pkg::btcr_queue_status_type q_status,
   input  wire btcr_pkg::btcr_job_type          q_job,
   output logic                                 q_pop,
   input  wire logic [2:0]                      draw_color,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [23:0]                          rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);
   import btcr_pkg::*;

   localparam logic [8:0] WIDTH_LIMIT  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_LIMIT = 9'(SCREEN_HEIGHT);

   logic        active_ff, active_in;
   logic [5:0]  pixel_ff, pixel_in;
   logic [63:0] bits_ff, bits_in;
   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  px_ff, px_in;
   logic [7:0]  py_ff, py_in;
   logic        on_ff, on_in;
   logic        off_ff, off_in;
   logic        last_ff, last_in;
   logic [2:0]  color_ff, color_in;
   logic        advance;
   logic        load;

   assign advance = active_ff && (!rsp_valid_ff || rsp_tready);
   assign load    = !active_ff || (advance && (pixel_ff == PIXEL_LAST));
   assign q_pop   = load && q_status.not_empty;

   always_comb begin
      active_in = active_ff;
      pixel_in  = pixel_ff;
      bits_in   = bits_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (load) begin
         active_in = q_status.not_empty;
         pixel_in  = 6'd0;
         bits_in   = btcr_glyph_bits(q_job.glyph);
         col_in    = q_job.col;
         row_in    = q_job.row;
      end else if (advance) begin
         pixel_in = pixel_ff + 6'd1;
         bits_in  = {1'b0, bits_ff[63:1]};
      end
   end

   always_comb begin
      px_in    = col_ff + {5'd0, pixel_ff[2:0]};
      py_in    = row_ff + {5'd0, pixel_ff[5:3]};
      on_in    = bits_ff[0];
      off_in   = ({1'b0, px_in} >= WIDTH_LIMIT) || ({1'b0, py_in} >= HEIGHT_LIMIT);
      last_in  = (pixel_ff == PIXEL_LAST);
      color_in = draw_color;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      bits_ff  <= bits_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      if (advance) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         on_ff    <= on_in;
         off_ff   <= off_in;
         last_ff  <= last_in;
         color_ff <= color_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, color_ff, py_ff, px_ff};
   assign rsp_tuser  = {off_ff, on_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== design/bitmap_text_character_renderer.sv =====
// Top level of the 8x8 bitmap text character renderer.
//
//   Channel  Direction  Carries
//   req_*    in         move or draw request beats
//   rsp_*    out        pixel write beats, 64 per drawn character
//   csr_*    in         draw color register writes
//
// The pixel engine's counter emits one pixel beat per cycle while rsp is not
// stalled, and starts the next queued glyph right after the last beat.
// A move only loads the front end's cursor register and produces no beat.
// The two-entry queue holds up to two draw jobs ahead of the engine.
// Reset clears the cursor, the draw color, the queue and the output valid flag.
// A stalled rsp beat holds the engine's counter; requests keep flowing
// until the queue fills.
`default_nettype none
`include "bitmap_text_character_renderer_defines.svh"

module bitmap_text_character_renderer #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // char_code, move_x, move_y
   input  wire logic        req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // pixel_x, pixel_y, pixel_color, zero pad
   output logic [1:0]       rsp_tuser,  // pixel_on, off_screen
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_data
);
   import btcr_pkg::*;

   btcr_queue_status_type q_status;
   btcr_job_type          push_job;
   btcr_job_type          pop_job;
   logic                  q_push;
   logic                  q_pop;
   logic [2:0]            draw_color_ff, draw_color_in;

   assign csr_ready     = 1'b1;
   assign draw_color_in = (csr_valid && csr_ready) ? csr_data : draw_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_color_ff <= 3'd0;
      end else begin
         draw_color_ff <= draw_color_in;
      end
   end

   btcr_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   btcr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_job(push_job),
      .pop     (q_pop),
      .pop_job (pop_job),
      .status  (q_status)
   );

   btcr_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .draw_color(draw_color_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   `BTCR_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid, "rsp valid after reset")
   `BTCR_ASSERT_NEXT(a_job_queued, clock, reset, q_push, q_status.not_empty, "draw job lost")
   `BTCR_ASSERT_SAME(a_push_room, clock, reset, q_push, !q_status.full, "push into full queue")
   `BTCR_ASSERT_SAME(a_off_screen, clock, reset, rsp_tvalid,
      rsp_tuser[1] == (({1'b0, rsp_tdata[7:0]} >= 9'(SCREEN_WIDTH)) ||
                       ({1'b0, rsp_tdata[15:8]} >= 9'(SCREEN_HEIGHT))),
      "off screen flag mismatch")

endmodule

`default_nettype wire

// ===== tb/sv/bitmap_text_character_renderer_test.sv =====
// Self-checking stream testbench for the 8x8 bitmap text character renderer.
`default_nettype none

module bitmap_text_character_renderer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import btcr_pkg::*;

   localparam int SCREEN_W = 128;
   localparam int SCREEN_H = 128;
   localparam int MOVE_SETTLE = 8;
   localparam int END_SETTLE = 80;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int PHASE_ITEMS = 81;
   localparam int PHASE_COUNT = 5;
   localparam int PLAN_ROWS = 26;

   typedef logic [0:7][7:0] glyph_rows_type;

   typedef enum logic [1:0] {
      ROW_MOVE,
      ROW_DRAW,
      ROW_COLOR
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type  kind;
      logic [7:0]     code;
      logic [7:0]     mx;
      logic [7:0]     my;
      logic           known;
      logic [7:0]     at_col;
      logic [7:0]     at_row;
      glyph_rows_type rows;
   } plan_row_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic       on;
      logic [2:0] color;
      logic       off;
      logic       last;
   } pixel_write_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // char_code, move_x, move_y
   logic        req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // pixel_x, pixel_y, pixel_color, zero pad
   logic [1:0]  rsp_tuser;   // pixel_on, off_screen
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_data;

   pixel_write_type pending_pixels[$];
   logic [7:0]      cursor_col_m = 8'd0;
   logic [7:0]      cursor_row_m = 8'd0;
   logic [2:0]      color_m = 3'd0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              ready_mode = 0;
   int              ready_left = 0;
   int              ready_period = 1;
   int              ready_hold = 0;
   int              ready_phase = 0;
   plan_row_type    directed_plan [PLAN_ROWS];

   bitmap_text_character_renderer #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [5:0] glyph_number(input logic [7:0] code);
      logic [7:0] d;
      if (code >= LOWER_FIRST && code <= LOWER_LAST) d = code - LOWER_FIRST;
      else if (code >= UPPER_FIRST && code <= UPPER_LAST) d = code - UPPER_FIRST;
      else if (code >= DIGIT_FIRST && code <= DIGIT_LAST) d = code - DIGIT_BIAS;
      else if (code == CHAR_DOT) d = {2'b00, GLYPH_DOT};
      else if (code == CHAR_COLON) d = {2'b00, GLYPH_COLON};
      else if (code == CHAR_BANG) d = {2'b00, GLYPH_BANG};
      else if (code == CHAR_DASH) d = {2'b00, GLYPH_DASH};
      else if (code == CHAR_UNDER) d = {2'b00, GLYPH_UNDER};
      else d = {2'b00, GLYPH_BLANK};
      return d[5:0];
   endfunction

   function automatic glyph_rows_type font_rows(input logic [5:0] g);
      glyph_rows_type r;
      case (g)
         6'd0:  r = {8'h04, 8'h0a, 8'h0a, 8'h0a, 8'h1f, 8'h11, 8'h11, 8'h11};
         6'd1:  r = {8'h07, 8'h09, 8'h09, 8'h09, 8'h0f, 8'h11, 8'h11, 8'h0f};
         6'd2:  r = {8'h0e, 8'h11, 8'h01, 8'h01, 8'h01, 8'h01, 8'h11, 8'h0e};
         6'd3:  r = {8'h07, 8'h09, 8'h11, 8'h11, 8'h11, 8'h11, 8'h09, 8'h07};
         6'd4:  r = {8'h1f, 8'h01, 8'h01, 8'h01, 8'h0f, 8'h01, 8'h01, 8'h1f};
         6'd5:  r = {8'h1f, 8'h01, 8'h01, 8'h01, 8'h0f, 8'h01, 8'h01, 8'h01};
         6'd6:  r = {8'h0e, 8'h11, 8'h01, 8'h01, 8'h19, 8'h11, 8'h11, 8'h0e};
         6'd7:  r = {8'h11, 8'h11, 8'h11, 8'h11, 8'h1f, 8'h11, 8'h11, 8'h11};
         6'd8:  r = {8'h1f, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h1f};
         6'd9:  r = {8'h1f, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h09, 8'h06};
         6'd10: r = {8'h11, 8'h09, 8'h05, 8'h03, 8'h07, 8'h09, 8'h11, 8'h11};
         6'd11: r = {8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h1f};
         6'd12: r = {8'h11, 8'h1b, 8'h15, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11};
         6'd13: r = {8'h11, 8'h11, 8'h13, 8'h15, 8'h15, 8'h19, 8'h11, 8'h11};
         6'd14: r = {8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e};
         6'd15: r = {8'h0f, 8'h11, 8'h11, 8'h11, 8'h0f, 8'h01, 8'h01, 8'h01};
         6'd16: r = {8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h09, 8'h16};
         6'd17: r = {8'h0f, 8'h11, 8'h11, 8'h11, 8'h0f, 8'h09, 8'h11, 8'h11};
         6'd18: r = {8'h0e, 8'h11, 8'h01, 8'h01, 8'h0e, 8'h10, 8'h11, 8'h0e};
         6'd19: r = {8'h1f, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04};
         6'd20: r = {8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e};
         6'd21: r = {8'h11, 8'h11, 8'h11, 8'h0a, 8'h0a, 8'h0a, 8'h04, 8'h04};
         6'd22: r = {8'h11, 8'h11, 8'h11, 8'h11, 8'h15, 8'h15, 8'h15, 8'h0a};
         6'd23: r = {8'h11, 8'h11, 8'h0a, 8'h04, 8'h04, 8'h0a, 8'h11, 8'h11};
         6'd24: r = {8'h11, 8'h11, 8'h11, 8'h0a, 8'h04, 8'h04, 8'h04, 8'h04};
         6'd25: r = {8'h1f, 8'h10, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h1f};
         6'd26: r = {8'h0e, 8'h11, 8'h15, 8'h15, 8'h15, 8'h15, 8'h11, 8'h0e};
         6'd27: r = {8'h06, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h1f};
         6'd28: r = {8'h0e, 8'h11, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h1f};
         6'd29: r = {8'h1f, 8'h10, 8'h08, 8'h04, 8'h08, 8'h10, 8'h11, 8'h0e};
         6'd30: r = {8'h10, 8'h11, 8'h11, 8'h11, 8'h1f, 8'h10, 8'h10, 8'h10};
         6'd31: r = {8'h1f, 8'h11, 8'h01, 8'h01, 8'h0e, 8'h10, 8'h11, 8'h0e};
         6'd32: r = {8'h0e, 8'h11, 8'h01, 8'h01, 8'h0f, 8'h11, 8'h11, 8'h0e};
         6'd33: r = {8'h1f, 8'h11, 8'h10, 8'h08, 8'h04, 8'h04, 8'h04, 8'h04};
         6'd34: r = {8'h0e, 8'h11, 8'h11, 8'h0e, 8'h11, 8'h11, 8'h11, 8'h0e};
         6'd35: r = {8'h0e, 8'h11, 8'h11, 8'h1e, 8'h10, 8'h10, 8'h10, 8'h10};
         6'd36: r = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04};
         6'd37: r = {8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00};
         6'd38: r = {8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00, 8'h04};
         6'd39: r = {8'h00, 8'h00, 8'h00, 8'h00, 8'h0e, 8'h00, 8'h00, 8'h00};
         6'd40: r = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1f};
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic queue_glyph(input logic [7:0] col, input logic [7:0] row,
                              input glyph_rows_type rows);
      pixel_write_type p;
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) begin
            p.x = col + c[7:0];
            p.y = row + r[7:0];
            p.on = rows[r][c];
            p.color = color_m;
            p.off = (p.x >= SCREEN_W) || (p.y >= SCREEN_H);
            p.last = (r == 7) && (c == 7);
            pending_pixels.push_back(p);
         end
      end
   endtask

   task automatic accept_request(input logic kind, input logic [7:0] code,
                                 input logic [7:0] mx, input logic [7:0] my,
                                 input logic known, input logic [7:0] at_col,
                                 input logic [7:0] at_row, input glyph_rows_type rows);
      if (kind == REQ_MOVE) begin
         cursor_col_m = mx;
         cursor_row_m = my;
      end else begin
         if (known)
            queue_glyph(at_col, at_row, rows);
         else
            queue_glyph(cursor_col_m, cursor_row_m, font_rows(glyph_number(code)));
         cursor_col_m = cursor_col_m + 8'd8;
         if (cursor_col_m > SCREEN_W - 8) begin
            cursor_col_m = 8'd0;
            cursor_row_m = cursor_row_m + 8'd8;
            if (cursor_row_m > SCREEN_H - 8)
               cursor_row_m = 8'd0;
         end
      end
   endtask

   task automatic drive_req(input logic kind, input logic [7:0] code,
                            input logic [7:0] mx, input logic [7:0] my,
                            input logic known, input logic [7:0] at_col,
                            input logic [7:0] at_row, input glyph_rows_type rows);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {my, mx, code};
      do @(posedge clock); while (!req_tready);
      accept_request(kind, code, mx, my, known, at_col, at_row, rows);
   endtask

   task automatic idle_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic write_color(input logic [2:0] value);
      idle_req(1);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (MOVE_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      color_m = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 4))
         0, 1: return 8'($urandom_range(0, 255));
         2: return LOWER_FIRST + 8'($urandom_range(0, 25));
         3: return UPPER_FIRST + 8'($urandom_range(0, 25));
         default: begin
            case ($urandom_range(0, 5))
               0: return CHAR_DOT;
               1: return CHAR_COLON;
               2: return CHAR_BANG;
               3: return CHAR_DASH;
               4: return CHAR_UNDER;
               default: return DIGIT_FIRST + 8'($urandom_range(0, 9));
            endcase
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(0, 7));
         2: return 8'($urandom_range(112, 135));
         default: return 8'($urandom_range(244, 255));
      endcase
   endfunction

   always @(negedge clock) begin : ready_pattern
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_left = $urandom_range(50, 400);
         ready_period = $urandom_range(2, 8);
         ready_hold = $urandom_range(1, ready_period - 1);
         ready_phase = 0;
      end else begin
         ready_left--;
      end
      ready_phase = (ready_phase + 1) % ready_period;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (ready_phase >= ready_hold);
      endcase
   end

   always @(posedge clock) begin : check_pixels
      pixel_write_type got;
      pixel_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[7:0];
         got.y = rsp_tdata[15:8];
         got.color = rsp_tdata[18:16];
         got.on = rsp_tuser[0];
         got.off = rsp_tuser[1];
         got.last = rsp_tlast;
         if (pending_pixels.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected pixel beat: x=%0d y=%0d on=%0b color=%0d off=%0b last=%0b",
                        got.x, got.y, got.on, got.color, got.off, got.last);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want || rsp_tdata[23:19] !== 5'd0) begin
               if (mismatch_count < 10) begin
                  $display("pixel mismatch: expected x=%0d y=%0d on=%0b color=%0d off=%0b last=%0b",
                           want.x, want.y, want.on, want.color, want.off, want.last);
                  $display("   got x=%0d y=%0d on=%0b color=%0d off=%0b last=%0b pad=%0h",
                           got.x, got.y, got.on, got.color, got.off, got.last,
                           rsp_tdata[23:19]);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      directed_plan = '{
         '{ROW_DRAW,  8'h00,       8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  CHAR_UNDER,  8'd0,   8'd0,   1'b1, 8'd8,   8'd0,
           {{7{8'h00}}, 8'h1f}},
         '{ROW_COLOR, 8'd7,        8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  LOWER_FIRST, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  UPPER_LAST,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  DIGIT_FIRST, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  DIGIT_LAST,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  CHAR_DOT,    8'd0,   8'd0,   1'b1, 8'd48,  8'd0,
           {{7{8'h00}}, 8'h04}},
         '{ROW_DRAW,  CHAR_COLON,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  CHAR_BANG,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  CHAR_DASH,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  LOWER_LAST,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  UPPER_FIRST, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_MOVE,  8'hff,       8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  8'hff,       8'd0,   8'd0,   1'b1, 8'd255, 8'd255, '0},
         '{ROW_DRAW,  8'd64,       8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_MOVE,  8'd0,        8'd250, 8'd10,  1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  8'd91,       8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  8'd96,       8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_MOVE,  8'd0,        8'd112, 8'd112, 1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  8'd47,       8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  CHAR_COLON,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_MOVE,  8'd0,        8'd116, 8'd120, 1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  8'd123,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_DRAW,  8'd77,       8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0},
         '{ROW_COLOR, 8'd0,        8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   '0}
      };
   end

   initial begin : stimulus
      int burst_left;
      int gap;
      logic [2:0] phase_color;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_MOVE;
      csr_valid = 1'b0;
      csr_data = '0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (directed_plan[i].kind == ROW_COLOR)
            write_color(directed_plan[i].code[2:0]);
         else
            drive_req(directed_plan[i].kind == ROW_DRAW ? REQ_DRAW : REQ_MOVE,
                      directed_plan[i].code, directed_plan[i].mx, directed_plan[i].my,
                      directed_plan[i].known, directed_plan[i].at_col,
                      directed_plan[i].at_row, directed_plan[i].rows);
         if ($urandom_range(0, 3) == 0)
            idle_req($urandom_range(1, 40));
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         phase_color = (ph == 0) ? 3'd7 : (ph == 1) ? 3'd0 : 3'($urandom_range(0, 7));
         write_color(phase_color);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150)
                                                 : $urandom_range(1, 6);
               idle_req(gap);
               burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            if ($urandom_range(0, 9) < 3)
               drive_req(REQ_MOVE, 8'($urandom_range(0, 255)), pick_coord(), pick_coord(),
                         1'b0, 8'd0, 8'd0, '0);
            else
               drive_req(REQ_DRAW, pick_code(), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'b0, 8'd0, 8'd0, '0);
         end
      end

      idle_req(1);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
